>>> rtl/core/fdtr_pkg.sv
// fdtr_pkg: shared types and constants for the fixed decimal token reader.
// Holds character codes, field widths and the power-of-ten scale table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fdtr_pkg;

   localparam int CHAR_W  = 8;
   localparam int FRAC_W  = 5;
   localparam int VALUE_W = 64;
   localparam int HALF_W  = VALUE_W / 2;

   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
   localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
   localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

   localparam logic [FRAC_W-1:0] FRAC_RESET = 5'd2;

   // parse phase codes
   localparam logic [1:0] PH_START = 2'd0;
   localparam logic [1:0] PH_WHOLE = 2'd1;
   localparam logic [1:0] PH_FRAC  = 2'd2;
   localparam logic [1:0] PH_STOP  = 2'd3;

   localparam int POW_N = 2 ** FRAC_W;

   typedef logic [VALUE_W-1:0] pow10_tbl_type [POW_N];

   // 10^k modulo 2^64, built at elaboration
   function automatic pow10_tbl_type pow10_table();
      pow10_tbl_type t;
      logic [VALUE_W-1:0] p;
      p = VALUE_W'(1);
      for (int i = 0; i < POW_N; i++) begin
         t[i] = p;
         p = p * VALUE_W'(10);
      end
      return t;
   endfunction

   localparam pow10_tbl_type POW10 = pow10_table();

endpackage

`default_nettype wire

>>> rtl/core/fdtr_ifs.sv
// Channel interfaces for the fixed decimal token reader: request, response
// and register write. Depends on fdtr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface fdtr_req_if;
   logic                          valid;
   logic                          ready;
   logic [fdtr_pkg::CHAR_W-1:0]   char_in;
   logic                          end_of_input;

   modport source (output valid, output char_in, output end_of_input, input ready);
   modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

interface fdtr_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [fdtr_pkg::VALUE_W-1:0]  value;
   logic                                 token_found;
   logic                                 semicolon_end;

   modport source (output valid, output value, output token_found, output semicolon_end,
                   input ready);
   modport sink   (input valid, input value, input token_found, input semicolon_end,
                   output ready);
endinterface

interface fdtr_csr_if;
   logic                          valid;
   logic                          ready;
   logic [fdtr_pkg::FRAC_W-1:0]   frac_digits;

   modport source (output valid, output frac_digits, input ready);
   modport sink   (input valid, input frac_digits, output ready);
endinterface

`default_nettype wire

>>> rtl/core/fixed_decimal_token_reader_top.sv
// Fixed decimal token reader, top level: character parser, scale multiply
// and result register. Depends on fdtr_pkg and the interfaces in fdtr_ifs.
//
// The block takes one character (or an end-of-input mark) per cycle and
// returns one response per finished token, and one for an end-of-input mark
// with no token open: the value scaled by 10^frac_digits, wrapping modulo
// 2^64, with found and semicolon flags. A request is taken every cycle while
// the pipeline can move; the token state updates at the accept edge, so a
// character can follow in the very next cycle. A finished token passes three
// register stages (token record, 32x32 partial products, sum and negate). The
// scale multiply is split into three 32x32 products. frac_digits is written
// through the csr channel, always ready, and is sampled when a fraction digit
// is taken and when a token ends.
`timescale 1ns / 1ps
`default_nettype none

module fixed_decimal_token_reader_top #(
   parameter int TOKEN_CAP = 64
) (
   input  wire        clock,
   input  wire        reset,
   fdtr_req_if.sink   req_ch,
   fdtr_rsp_if.source rsp_ch,
   fdtr_csr_if.sink   csr_ch
);

   localparam int CNT_W = (TOKEN_CAP > 2) ? $clog2(TOKEN_CAP) : 1;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(TOKEN_CAP - 1);
   localparam int VW = fdtr_pkg::VALUE_W;
   localparam int HW = fdtr_pkg::HALF_W;
   localparam int FW = fdtr_pkg::FRAC_W;

   // configuration
   logic [FW-1:0] frac_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frac_ff <= fdtr_pkg::FRAC_RESET;
      end else if (csr_ch.valid) begin
         frac_ff <= csr_ch.frac_digits;
      end
   end
   assign csr_ch.ready = 1'b1;

   // token state
   logic          in_tok_ff, in_tok_in;
   logic [1:0]    phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic          neg_ff, neg_in;
   logic [VW-1:0] acc_ff, acc_in;
   logic [FW-1:0] fcnt_ff, fcnt_in;

   // pipeline
   logic          s1_v_ff, s1_v_in;
   logic [VW-1:0] s1_acc_ff;
   logic [VW-1:0] s1_scale_ff;
   logic          s1_neg_ff, s1_found_ff, s1_semi_ff;

   logic          s2_v_ff;
   logic [VW-1:0] s2_ll_ff;
   logic [HW-1:0] s2_lh_ff, s2_hl_ff;
   logic          s2_neg_ff, s2_found_ff, s2_semi_ff;

   logic          out_v_ff;
   logic [VW-1:0] out_val_ff;
   logic          out_found_ff, out_semi_ff;

   logic out_ready, s2_adv, s1_adv, req_fire;

   assign out_ready    = !out_v_ff || rsp_ch.ready;
   assign s2_adv       = !s2_v_ff || out_ready;
   assign s1_adv       = !s1_v_ff || s2_adv;
   assign req_ch.ready = s1_adv;
   assign req_fire     = req_ch.valid && s1_adv;

   // character decode and next token state
   logic [fdtr_pkg::CHAR_W-1:0] c;
   logic is_space, is_delim, is_digit, is_sign, emit, semi;
   logic [1:0] eff_phase;
   logic [VW-1:0] acc_x10;
   logic [VW-1:0] scale;
   logic [FW-1:0] exp_k;

   always_comb begin
      c        = req_ch.char_in;
      is_space = (c == fdtr_pkg::CH_SPACE) || (c == fdtr_pkg::CH_TAB) ||
                 (c == fdtr_pkg::CH_LF) || (c == fdtr_pkg::CH_CR);
      is_delim = is_space || (c == fdtr_pkg::CH_COMMA) || (c == fdtr_pkg::CH_SEMI);
      is_digit = (c >= fdtr_pkg::CH_ZERO) && (c <= fdtr_pkg::CH_NINE);
      is_sign  = (c == fdtr_pkg::CH_PLUS) || (c == fdtr_pkg::CH_MINUS);
      acc_x10  = (acc_ff << 3) + (acc_ff << 1) +
                 (is_digit ? VW'(c - fdtr_pkg::CH_ZERO) : VW'(0));
      eff_phase = (phase_ff == fdtr_pkg::PH_START) ? fdtr_pkg::PH_WHOLE : phase_ff;

      in_tok_in = in_tok_ff;
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      fcnt_in   = fcnt_ff;
      emit      = 1'b0;
      semi      = 1'b0;

      if (req_ch.end_of_input) begin
         emit = 1'b1;
      end else if (is_delim) begin
         // leading whitespace is skipped; anything else closes the token
         emit = in_tok_ff || !is_space;
         semi = (c == fdtr_pkg::CH_SEMI);
      end else begin
         in_tok_in = 1'b1;
         if (cnt_ff < CNT_MAX) begin
            cnt_in   = cnt_ff + CNT_W'(1);
            phase_in = eff_phase;
            if (phase_ff == fdtr_pkg::PH_START && is_sign) begin
               neg_in = (c == fdtr_pkg::CH_MINUS);
            end else begin
               unique case (eff_phase)
                  fdtr_pkg::PH_WHOLE: begin
                     if (is_digit) begin
                        acc_in = acc_x10;
                     end else if (c == fdtr_pkg::CH_POINT) begin
                        phase_in = fdtr_pkg::PH_FRAC;
                     end else begin
                        phase_in = fdtr_pkg::PH_STOP;
                     end
                  end
                  fdtr_pkg::PH_FRAC: begin
                     if (!is_digit) begin
                        phase_in = fdtr_pkg::PH_STOP;
                     end else if (fcnt_ff < frac_ff) begin
                        acc_in  = acc_x10;
                        fcnt_in = fcnt_ff + FW'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end

      if (emit) begin
         in_tok_in = 1'b0;
         phase_in  = fdtr_pkg::PH_START;
         cnt_in    = '0;
         neg_in    = 1'b0;
         acc_in    = '0;
         fcnt_in   = '0;
      end

      // missing fraction digits scale the token; none if already past q
      exp_k = (fcnt_ff < frac_ff) ? (frac_ff - fcnt_ff) : '0;
      scale = fdtr_pkg::POW10[exp_k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_tok_ff <= 1'b0;
         phase_ff  <= fdtr_pkg::PH_START;
         cnt_ff    <= '0;
         neg_ff    <= 1'b0;
         acc_ff    <= '0;
         fcnt_ff   <= '0;
      end else if (req_fire) begin
         in_tok_ff <= in_tok_in;
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         neg_ff    <= neg_in;
         acc_ff    <= acc_in;
         fcnt_ff   <= fcnt_in;
      end
   end

   // stage 1: token record
   assign s1_v_in = s1_adv ? (req_fire && emit) : s1_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_acc_ff   <= acc_ff;
         s1_scale_ff <= scale;
         s1_neg_ff   <= neg_ff;
         s1_found_ff <= in_tok_ff || !req_ch.end_of_input;
         s1_semi_ff  <= semi && !req_ch.end_of_input;
      end
   end

   // stage 2: partial products of the low 64 bits of acc * scale
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_adv) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         s2_ll_ff    <= VW'(s1_acc_ff[HW-1:0]) * VW'(s1_scale_ff[HW-1:0]);
         s2_lh_ff    <= s1_acc_ff[HW-1:0] * s1_scale_ff[VW-1:HW];
         s2_hl_ff    <= s1_acc_ff[VW-1:HW] * s1_scale_ff[HW-1:0];
         s2_neg_ff   <= s1_neg_ff;
         s2_found_ff <= s1_found_ff;
         s2_semi_ff  <= s1_semi_ff;
      end
   end

   // stage 3: sum, sign, result register
   logic [VW-1:0] prod;
   logic [HW-1:0] cross_sum;

   always_comb begin
      cross_sum = s2_lh_ff + s2_hl_ff;
      prod      = s2_ll_ff + {cross_sum, {HW{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_ready) begin
         out_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         out_val_ff   <= s2_neg_ff ? (VW'(0) - prod) : prod;
         out_found_ff <= s2_found_ff;
         out_semi_ff  <= s2_semi_ff;
      end
   end

   assign rsp_ch.valid         = out_v_ff;
   assign rsp_ch.value         = out_val_ff;
   assign rsp_ch.token_found   = out_found_ff;
   assign rsp_ch.semicolon_end = out_semi_ff;

   // checks
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !in_tok_ff |-> (acc_ff == '0) && !neg_ff && (cnt_ff == '0) && (fcnt_ff == '0))
      else $error("token state not cleared outside a token");

   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_MAX)
      else $error("character count past cap");

   a_phase_tok: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != fdtr_pkg::PH_START) |-> in_tok_ff)
      else $error("parse phase advanced outside a token");

   a_eoi_ends: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.end_of_input) |=> !in_tok_ff && s1_v_ff)
      else $error("end of input did not close token and emit");

   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && !s1_found_ff) |-> (s1_acc_ff == '0) && !s1_neg_ff && !s1_semi_ff)
      else $error("not-found record carries data");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// tb_top: self-checking bench for fixed_decimal_token_reader_top. Character
// requests go in, scaled token values are predicted locally and checked.
// Depends on fdtr_pkg, the channel interfaces in fdtr_ifs and the top RTL.
`timescale 1ns / 1ps

module tb_top;

   localparam int TOKEN_CAP     = 64;
   localparam int SETTLE_CYCLES = 8;   // pipeline is 3 deep, leave margin
   localparam int N_PHASES      = 9;
   localparam int PHASE_CHARS   = 100;
   localparam logic [fdtr_pkg::CHAR_W-1:0] CH_LETTER_X = 8'h78;

   typedef struct packed {
      logic [fdtr_pkg::VALUE_W-1:0] value;
      logic                         found;
      logic                         semi;
   } token_result_type;

   typedef struct packed {
      logic [fdtr_pkg::CHAR_W-1:0] ch;
      logic                        eoi;
      logic                        typed;   // res holds the literal answer
      token_result_type            res;
   } dir_row_type;

   localparam token_result_type NO_RES = '0;
   localparam int DIR_N = 25;

   // frac_digits is 2 out of reset
   dir_row_type dir_tab [DIR_N] = '{
      '{fdtr_pkg::CH_ZERO,         1'b1, 1'b1, NO_RES},   // end of input, no token
      '{fdtr_pkg::CH_SPACE,        1'b0, 1'b0, NO_RES},
      '{fdtr_pkg::CH_TAB,          1'b0, 1'b0, NO_RES},
      '{fdtr_pkg::CH_COMMA,        1'b0, 1'b1, '{64'd0, 1'b1, 1'b0}},
      '{fdtr_pkg::CH_SEMI,         1'b0, 1'b1, '{64'd0, 1'b1, 1'b1}},
      '{fdtr_pkg::CH_MINUS,        1'b0, 1'b0, NO_RES},
      '{fdtr_pkg::CH_ZERO + 8'd1,  1'b0, 1'b0, NO_RES},
      '{fdtr_pkg::CH_POINT,        1'b0, 1'b0, NO_RES},
      '{fdtr_pkg::CH_ZERO + 8'd5,  1'b0, 1'b0, NO_RES},
      '{fdtr_pkg::CH_ZERO + 8'd7,  1'b0, 1'b0, NO_RES},
      '{fdtr_pkg::CH_ZERO + 8'd9,  1'b0, 1'b0, NO_RES},   // past frac_digits, dropped
      '{fdtr_pkg::CH_SEMI,         1'b0, 1'b1, '{-64'sd157, 1'b1, 1'b1}},
      '{fdtr_pkg::CH_PLUS,         1'b0, 1'b0, NO_RES},
      '{fdtr_pkg::CH_ZERO + 8'd4,  1'b0, 1'b0, NO_RES},
      '{CH_LETTER_X,               1'b0, 1'b0, NO_RES},   // stops parsing
      '{fdtr_pkg::CH_ZERO + 8'd9,  1'b0, 1'b0, NO_RES},
      '{fdtr_pkg::CH_LF,           1'b0, 1'b0, NO_RES},
      '{8'h00,                     1'b0, 1'b0, NO_RES},
      '{fdtr_pkg::CH_CR,           1'b0, 1'b0, NO_RES},
      '{fdtr_pkg::CH_POINT,        1'b0, 1'b0, NO_RES},
      '{fdtr_pkg::CH_ZERO + 8'd5,  1'b0, 1'b0, NO_RES},
      '{fdtr_pkg::CH_ZERO,         1'b1, 1'b0, NO_RES},   // ends open token
      '{fdtr_pkg::CH_ZERO,         1'b1, 1'b1, NO_RES},
      '{8'hFF,                     1'b0, 1'b0, NO_RES},
      '{fdtr_pkg::CH_COMMA,        1'b0, 1'b0, NO_RES}
   };

   logic clock;
   logic reset;

   fdtr_req_if req_if ();
   fdtr_rsp_if rsp_if ();
   fdtr_csr_if csr_if ();

   fixed_decimal_token_reader_top #(
      .TOKEN_CAP (TOKEN_CAP)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // local copy of the parser state
   logic [fdtr_pkg::FRAC_W-1:0]  frac_cfg;
   bit                           tk_open;
   logic [1:0]                   tk_phase;
   int                           tk_chars;
   bit                           tk_neg;
   logic [fdtr_pkg::VALUE_W-1:0] tk_acc;
   int                           tk_fracs;

   token_result_type due_tokens [$];

   int gap_pct;
   int stall_pct;
   int n_sent;
   int n_results;
   int n_settings;
   int n_errors;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("tb_top failed");
      $finish;
   end

   function automatic void clear_token();
      tk_open  = 1'b0;
      tk_phase = fdtr_pkg::PH_START;
      tk_chars = 0;
      tk_neg   = 1'b0;
      tk_acc   = '0;
      tk_fracs = 0;
   endfunction

   function automatic token_result_type close_token(input bit semi);
      token_result_type r;
      logic [fdtr_pkg::VALUE_W-1:0] v;
      v = tk_acc;
      // no scaling when more fraction digits were taken than q now asks
      for (int k = tk_fracs; k < int'(frac_cfg); k++)
         v = v * 64'd10;
      if (tk_neg)
         v = 64'd0 - v;
      r.value = v;
      r.found = 1'b1;
      r.semi  = semi;
      clear_token();
      return r;
   endfunction

   function automatic void fold_char(input logic [fdtr_pkg::CHAR_W-1:0] c);
      bit                           dig;
      logic [fdtr_pkg::VALUE_W-1:0] d;
      dig = (c >= fdtr_pkg::CH_ZERO) && (c <= fdtr_pkg::CH_NINE);
      d   = dig ? fdtr_pkg::VALUE_W'(c - fdtr_pkg::CH_ZERO) : '0;
      if (tk_phase == fdtr_pkg::PH_START) begin
         tk_phase = fdtr_pkg::PH_WHOLE;
         if (c == fdtr_pkg::CH_PLUS || c == fdtr_pkg::CH_MINUS) begin
            tk_neg = (c == fdtr_pkg::CH_MINUS);
            return;
         end
      end
      if (tk_phase == fdtr_pkg::PH_WHOLE) begin
         if (dig)
            tk_acc = tk_acc * 64'd10 + d;
         else if (c == fdtr_pkg::CH_POINT)
            tk_phase = fdtr_pkg::PH_FRAC;
         else
            tk_phase = fdtr_pkg::PH_STOP;
      end else if (tk_phase == fdtr_pkg::PH_FRAC) begin
         if (dig) begin
            if (tk_fracs < int'(frac_cfg)) begin
               tk_acc = tk_acc * 64'd10 + d;
               tk_fracs++;
            end
         end else begin
            tk_phase = fdtr_pkg::PH_STOP;
         end
      end
   endfunction

   // returns 1 when the request produces a response
   function automatic bit parse_char(input logic [fdtr_pkg::CHAR_W-1:0] c, input bit eoi,
                                     output token_result_type r);
      bit sp;
      r  = '0;
      sp = (c == fdtr_pkg::CH_SPACE) || (c == fdtr_pkg::CH_TAB) ||
           (c == fdtr_pkg::CH_LF) || (c == fdtr_pkg::CH_CR);
      if (eoi) begin
         if (tk_open)
            r = close_token(1'b0);
         return 1'b1;
      end
      if (!tk_open && sp)
         return 1'b0;
      if (sp || c == fdtr_pkg::CH_COMMA || c == fdtr_pkg::CH_SEMI) begin
         r = close_token(c == fdtr_pkg::CH_SEMI);
         return 1'b1;
      end
      tk_open = 1'b1;
      if (tk_chars < TOKEN_CAP - 1) begin
         tk_chars++;
         fold_char(c);
      end
      return 1'b0;
   endfunction

   // called and returns at a falling edge; valid stays high for the next request
   task automatic send_char(input logic [fdtr_pkg::CHAR_W-1:0] c, input bit eoi,
                            input bit typed = 1'b0, input token_result_type want = '0);
      token_result_type r;
      bit               has;
      if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_if.valid        = 1'b1;
      req_if.char_in      = c;
      req_if.end_of_input = eoi;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      has = parse_char(c, eoi, r);
      if (has)
         due_tokens.push_back(typed ? want : r);
      n_sent++;
      @(negedge clock);
   endtask

   task automatic set_frac(input logic [fdtr_pkg::FRAC_W-1:0] f);
      req_if.valid = 1'b0;
      while (due_tokens.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_if.valid       = 1'b1;
      csr_if.frac_digits = f;
      @(posedge clock);
      while (!csr_if.ready)
         @(posedge clock);
      frac_cfg = f;
      n_settings++;
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   function automatic logic [fdtr_pkg::CHAR_W-1:0] space_char();
      case ($urandom_range(0, 3))
         0:       return fdtr_pkg::CH_SPACE;
         1:       return fdtr_pkg::CH_TAB;
         2:       return fdtr_pkg::CH_LF;
         default: return fdtr_pkg::CH_CR;
      endcase
   endfunction

   task automatic send_digits(input int n);
      repeat (n) send_char(fdtr_pkg::CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
   endtask

   // one token, mostly well formed; close=0 leaves it open
   task automatic send_token(input bit close);
      int kind;
      int pick;
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) send_char(space_char(), 1'b0);
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
         // empty token
      end else if (kind < 14) begin
         repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(0, 255)), 1'b0);
      end else if (kind < 19) begin
         // 62 to 82 characters, mostly past the token cap, wraps the accumulator too
         send_char($urandom_range(0, 1) ? fdtr_pkg::CH_MINUS : fdtr_pkg::CH_PLUS, 1'b0);
         send_digits($urandom_range(40, 50));
         send_char(fdtr_pkg::CH_POINT, 1'b0);
         send_digits($urandom_range(20, 30));
      end else begin
         pick = $urandom_range(0, 2);
         if (pick == 1)
            send_char(fdtr_pkg::CH_PLUS, 1'b0);
         else if (pick == 2)
            send_char(fdtr_pkg::CH_MINUS, 1'b0);
         send_digits(($urandom_range(0, 4) == 0) ? $urandom_range(0, 22)
                                                 : $urandom_range(1, 5));
         if ($urandom_range(0, 1)) begin
            send_char(fdtr_pkg::CH_POINT, 1'b0);
            send_digits(($urandom_range(0, 4) == 0) ? $urandom_range(0, 25)
                                                    : $urandom_range(0, 4));
         end
         if ($urandom_range(0, 9) == 0) begin
            send_char(8'($urandom_range(0, 255)), 1'b0);
            send_digits($urandom_range(0, 3));
         end
      end
      if (!close)
         return;
      pick = $urandom_range(0, 9);
      if (pick < 3)
         send_char(space_char(), 1'b0);
      else if (pick < 5)
         send_char(fdtr_pkg::CH_COMMA, 1'b0);
      else if (pick < 7)
         send_char(fdtr_pkg::CH_SEMI, 1'b0);
      else
         send_char(8'($urandom_range(0, 255)), 1'b1);
      if (pick == 9)
         send_char(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // response side stalls in bursts
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_if.ready = 1'b0;
         end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_if.ready = 1'b0;
            repeat ($urandom_range(1, 17) - 1) @(negedge clock);
         end else begin
            rsp_if.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      token_result_type w;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         n_results++;
         if (due_tokens.size() == 0) begin
            n_errors++;
            $display("%0t: response with none expected, value %h found %b semi %b",
                     $time, rsp_if.value, rsp_if.token_found, rsp_if.semicolon_end);
         end else begin
            w = due_tokens.pop_front();
            if (rsp_if.value !== w.value) begin
               n_errors++;
               $display("%0t: value expected %h actual %h", $time, w.value, rsp_if.value);
            end
            if (rsp_if.token_found !== w.found) begin
               n_errors++;
               $display("%0t: token_found expected %b actual %b",
                        $time, w.found, rsp_if.token_found);
            end
            if (rsp_if.semicolon_end !== w.semi) begin
               n_errors++;
               $display("%0t: semicolon_end expected %b actual %b",
                        $time, w.semi, rsp_if.semicolon_end);
            end
         end
      end
   end

   initial begin
      int start;
      logic [fdtr_pkg::FRAC_W-1:0] f;
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.char_in      = '0;
      req_if.end_of_input = 1'b0;
      csr_if.valid        = 1'b0;
      csr_if.frac_digits  = '0;
      gap_pct             = 0;
      stall_pct           = 0;
      n_sent              = 0;
      n_results           = 0;
      n_settings          = 0;
      n_errors            = 0;
      frac_cfg            = fdtr_pkg::FRAC_RESET;
      clear_token();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      gap_pct   = 15;
      stall_pct = 15;
      for (int i = 0; i < DIR_N; i++)
         send_char(dir_tab[i].ch, dir_tab[i].eoi, dir_tab[i].typed, dir_tab[i].res);

      // q changes while a token is open
      send_char(fdtr_pkg::CH_ZERO + 8'd1, 1'b0);
      send_char(fdtr_pkg::CH_ZERO + 8'd2, 1'b0);
      send_char(fdtr_pkg::CH_POINT, 1'b0);
      send_char(fdtr_pkg::CH_ZERO + 8'd3, 1'b0);
      set_frac(5'd31);
      send_char(fdtr_pkg::CH_ZERO + 8'd4, 1'b0);
      send_char(fdtr_pkg::CH_SEMI, 1'b0);

      for (int p = 0; p < N_PHASES; p++) begin
         case (p)
            0:       f = 5'd0;
            1:       f = 5'd31;
            2:       f = 5'd18;
            3:       f = fdtr_pkg::FRAC_RESET;
            default: f = fdtr_pkg::FRAC_W'($urandom_range(0, 31));
         endcase
         set_frac(f);
         if (p == N_PHASES - 1 || p % 3 == 1) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else begin
            gap_pct   = $urandom_range(5, 30);
            stall_pct = $urandom_range(5, 30);
         end
         start = n_sent;
         while (n_sent - start < PHASE_CHARS)
            send_token(1'b1);
         if (p < N_PHASES - 1 && $urandom_range(0, 1))
            send_token(1'b0);
      end
      send_char(8'($urandom_range(0, 255)), 1'b1);
      req_if.valid = 1'b0;

      while (due_tokens.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("sent %0d character requests, checked %0d token responses", n_sent, n_results);
      $display("over %0d fraction-digit settings, q from 0 to 31", n_settings);
      if (n_errors == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

>>> fixed_decimal_token_reader_top.f
rtl/core/fdtr_pkg.sv
rtl/core/fdtr_ifs.sv
rtl/core/fixed_decimal_token_reader_top.sv
tb/tb_top.sv
